FILE: rtl/core/vnfr_pkg.sv
`timescale 1ns / 1ps
// Package for the vector normalizer: single-precision constants and
// combinational multiply/add helpers (RNE, flush-to-zero, canonical NaN). No dependencies.
package vnfr_pkg;

   localparam logic [31:0] QNAN       = 32'h7FC0_0000;
   localparam logic [31:0] RSQRT_MAGIC = 32'h5F37_59DF;
   localparam logic [31:0] FP_HALF    = 32'h3F00_0000;
   localparam logic [31:0] FP_ONE_P5  = 32'h3FC0_0000;
   localparam logic [31:0] FP_EPS     = 32'h3400_0000;
   localparam logic [31:0] FP_ONE     = 32'h3F80_0000;

   // Per-stage pipeline payload; each stage uses the fields it needs
   typedef struct packed {
      logic             good;
      logic [3:0][31:0] raw;
      logic [3:0][31:0] vt;
      logic [3:0][31:0] sq;
      logic [31:0]      acc;
      logic [31:0]      half;
      logic [31:0]      r;
      logic [31:0]      t;
   } stage_type;

   // Flush subnormal to signed zero, canonical NaN
   function automatic logic [31:0] fp_fix(input logic [31:0] a);
      logic [31:0] res;
      res = a;
      if (a[30:23] == 8'h00) begin
         res = {a[31], 31'd0};
      end else if (a[30:23] == 8'hFF && a[22:0] != 23'd0) begin
         res = QNAN;
      end
      return res;
   endfunction

   // Final rounding carry, underflow flush and overflow
   function automatic logic [31:0] fp_pack(input logic s, input logic signed [10:0] e_in,
                                           input logic [24:0] mant);
      logic signed [10:0] e;
      logic [22:0]        frac;
      logic [31:0]        res;
      e    = e_in;
      frac = mant[22:0];
      if (mant[24]) begin
         e    = e + 11'sd1;
         frac = 23'd0;
      end
      if (!(mant[24] || mant[23])) begin
         res = {s, 31'd0};
      end else if (e >= 11'sd255) begin
         res = {s, 8'hFF, 23'd0};
      end else begin
         res = {s, e[7:0], frac};
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [47:0]        prod, m;
      logic signed [10:0] e, shf;
      logic [5:0]         sh;
      logic               lost, g, st, rnd;
      logic [24:0]        mant;
      logic [31:0]        res;
      s      = a[31] ^ b[31];
      a_nan  = a[30:23] == 8'hFF && a[22:0] != 23'd0;
      b_nan  = b[30:23] == 8'hFF && b[22:0] != 23'd0;
      a_inf  = a[30:23] == 8'hFF && a[22:0] == 23'd0;
      b_inf  = b[30:23] == 8'hFF && b[22:0] == 23'd0;
      a_zero = a[30:23] == 8'h00;
      b_zero = b[30:23] == 8'h00;
      prod   = {1'b1, a[22:0]} * {1'b1, b[22:0]};
      e      = $signed({3'b000, a[30:23]}) + $signed({3'b000, b[30:23]}) - 11'sd127;
      if (prod[47]) begin
         e = e + 11'sd1;
      end else begin
         prod = prod << 1;
      end
      // denormalize toward the subnormal grid before rounding
      sh = 6'd0;
      if (e < 11'sd1) begin
         shf = 11'sd1 - e;
         sh  = (shf > 11'sd48) ? 6'd48 : shf[5:0];
         e   = 11'sd1;
      end
      lost = |(prod & ((48'd1 << sh) - 48'd1));
      m    = prod >> sh;
      g    = m[23];
      st   = (|m[22:0]) | lost;
      rnd  = g & (st | m[24]);
      mant = {1'b0, m[47:24]} + {24'd0, rnd};
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         res = QNAN;
      end else if (a_inf || b_inf) begin
         res = {s, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         res = {s, 31'd0};
      end else begin
         res = fp_pack(s, e, mant);
      end
      return res;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] cnt;
      cnt = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) cnt = 5'(26 - i);
      end
      return cnt;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [31:0]        big, sml, res;
      logic [7:0]         d;
      logic [26:0]        mbig, msml, algn, n;
      logic               lost, rnd;
      logic [27:0]        sum;
      logic signed [10:0] e;
      logic [4:0]         lz, sh;
      logic [24:0]        mant;
      a_nan  = a[30:23] == 8'hFF && a[22:0] != 23'd0;
      b_nan  = b[30:23] == 8'hFF && b[22:0] != 23'd0;
      a_inf  = a[30:23] == 8'hFF && a[22:0] == 23'd0;
      b_inf  = b[30:23] == 8'hFF && b[22:0] == 23'd0;
      a_zero = a[30:23] == 8'h00;
      b_zero = b[30:23] == 8'h00;
      // order by magnitude
      if (b[30:0] > a[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      d    = big[30:23] - sml[30:23];
      mbig = {1'b1, big[22:0], 3'b000};
      msml = {1'b1, sml[22:0], 3'b000};
      if (d >= 8'd27) begin
         algn = 27'd1;
      end else begin
         lost = |(msml & ((27'd1 << d[4:0]) - 27'd1));
         algn = (msml >> d[4:0]) | {26'd0, lost};
      end
      if (big[31] ^ sml[31]) begin
         sum = {1'b0, mbig} - {1'b0, algn};
      end else begin
         sum = {1'b0, mbig} + {1'b0, algn};
      end
      e = $signed({3'b000, big[30:23]});
      // normalize; left shift is limited at the smallest exponent
      if (sum[27]) begin
         n = {sum[27:2], sum[1] | sum[0]};
         e = e + 11'sd1;
      end else begin
         lz = lzc27(sum[26:0]);
         sh = (11'(lz) < e - 11'sd1) ? lz : 5'(e - 11'sd1);
         n  = sum[26:0] << sh;
         e  = e - 11'(sh);
      end
      rnd  = n[2] & ((|n[1:0]) | n[3]);
      mant = {1'b0, n[26:3]} + {24'd0, rnd};
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         res = QNAN;
      end else if (a_inf) begin
         res = a;
      end else if (b_inf) begin
         res = b;
      end else if (a_zero && b_zero) begin
         res = {a[31] & b[31], 31'd0};
      end else if (a_zero) begin
         res = b;
      end else if (b_zero) begin
         res = a;
      end else if (sum == 28'd0) begin
         res = 32'd0;
      end else begin
         res = fp_pack(big[31], e, mant);
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/vector_normalize_fast_rsqrt_top.sv
`timescale 1ns / 1ps
// One vector per cycle is accepted while the output is not stalled.
// The chain is squares with target scaling, three adds, seed, two Newton steps of
// three multiplies and one subtract each, and a final scale, each step in its own stage.
// Stalls back-pressure stage by stage; empty stages still fill under a stall.
// Synchronous active-high reset clears stage valids and sets target length to 1.0.
// Depends on vnfr_pkg.
module vector_normalize_fast_rsqrt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_in_x,
   input  logic [31:0] req_in_y,
   input  logic [31:0] req_in_z,
   input  logic [31:0] req_in_w,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [31:0] rsp_out_w,
   output logic        rsp_ok,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import vnfr_pkg::*;

   localparam int NS = 14;

   logic [31:0]     target_ff;
   logic [NS-1:0]   val_ff;
   logic [NS-1:0]   en;
   stage_type       st_ff [NS];
   stage_type       st_in [NS];
   logic [3:0][31:0] raw;
   logic [31:0]     tl;
   logic            fin;

   // target length register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= FP_ONE;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // per-stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[NS-1] = !val_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !val_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   // stage datapath
   always_comb begin
      raw = {req_in_w, req_in_z, req_in_y, req_in_x};
      tl  = fp_fix(target_ff);
      fin = 1'b1;
      st_in[0] = '0;
      for (int i = 0; i < 4; i++) begin
         if (raw[i][30:23] == 8'hFF) fin = 1'b0;
         st_in[0].raw[i] = raw[i];
         st_in[0].sq[i]  = fp_mul(fp_fix(raw[i]), fp_fix(raw[i]));
         st_in[0].vt[i]  = fp_mul(fp_fix(raw[i]), tl);
      end
      st_in[0].good = fin;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
      end
      // squared length, left to right
      st_in[1].acc = fp_add(st_ff[0].sq[0], st_ff[0].sq[1]);
      st_in[2].acc = fp_add(st_ff[1].acc, st_ff[1].sq[2]);
      st_in[3].acc = fp_add(st_ff[2].acc, st_ff[2].sq[3]);
      // length check, half and bit-trick seed
      st_in[4].good = st_ff[3].good && !st_ff[3].acc[31] && (st_ff[3].acc[30:0] >= FP_EPS[30:0]);
      st_in[4].half = fp_mul(FP_HALF, st_ff[3].acc);
      st_in[4].r    = fp_fix(RSQRT_MAGIC - {1'b0, st_ff[3].acc[31:1]});
      // first Newton step
      st_in[5].t  = fp_mul(st_ff[4].half, st_ff[4].r);
      st_in[6].t  = fp_mul(st_ff[5].t, st_ff[5].r);
      st_in[7].t  = fp_add(FP_ONE_P5, {~st_ff[6].t[31], st_ff[6].t[30:0]});
      st_in[8].r  = fp_mul(st_ff[7].r, st_ff[7].t);
      // second Newton step
      st_in[9].t  = fp_mul(st_ff[8].half, st_ff[8].r);
      st_in[10].t = fp_mul(st_ff[9].t, st_ff[9].r);
      st_in[11].t = fp_add(FP_ONE_P5, {~st_ff[10].t[31], st_ff[10].t[30:0]});
      st_in[12].r = fp_mul(st_ff[11].r, st_ff[11].t);
      // final scale or pass-through
      for (int i = 0; i < 4; i++) begin
         st_in[13].vt[i] = st_ff[12].good ? fp_mul(st_ff[12].vt[i], st_ff[12].r)
                                          : st_ff[12].raw[i];
      end
   end

   // stage valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         if (en[0]) val_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) val_ff[k] <= val_ff[k-1];
         end
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

   assign rsp_valid = val_ff[NS-1];
   assign rsp_out_x = st_ff[NS-1].vt[0];
   assign rsp_out_y = st_ff[NS-1].vt[1];
   assign rsp_out_z = st_ff[NS-1].vt[2];
   assign rsp_out_w = st_ff[NS-1].vt[3];
   assign rsp_ok    = st_ff[NS-1].good;

   // empty output stage never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !val_ff[NS-1] |-> req_ready)
      else $error("input blocked with empty output stage");

   // an input transfer lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> val_ff[0])
      else $error("accepted vector lost at first stage");

   // a stalled result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(st_ff[NS-1])))
      else $error("stalled result changed");

   // a mid-pipe item moves forward when its stage advances
   a_move: assert property (@(posedge clock) disable iff (reset)
      (val_ff[6] && en[7]) |=> val_ff[7])
      else $error("item dropped between Newton stages");

endmodule

FILE: test/vector_normalize_fast_rsqrt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the vector normalizer: watches both transfer channels and the register
// write port, predicts each result with a bit-exact single-precision model of its own.
// Depends on vnfr_pkg for the float constants.
module vector_normalize_fast_rsqrt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_in_x,
   input  logic [31:0] req_in_y,
   input  logic [31:0] req_in_z,
   input  logic [31:0] req_in_w,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_out_x,
   input  logic [31:0] rsp_out_y,
   input  logic [31:0] rsp_out_z,
   input  logic [31:0] rsp_out_w,
   input  logic        rsp_ok,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          fail_count,
   output int          pending,
   output int          ok_count,
   output int          reject_count
);
   import vnfr_pkg::*;

   typedef struct {
      logic [3:0][31:0] comp;
      logic             ok;
   } norm_result_type;

   norm_result_type expected_q[$];
   logic [31:0]     length_reg;

   // Subnormal to signed zero, any NaN to the canonical one
   function automatic logic [31:0] fp32_fix(input logic [31:0] a);
      if (a[30:23] == 8'h00) return {a[31], 31'd0};
      if (a[30:23] == 8'hFF && a[22:0] != 23'd0) return QNAN;
      return a;
   endfunction

   // Round sig * 2^e2 to single (RNE, gradual underflow), then flush subnormals
   function automatic logic [31:0] fp32_round(input logic s, input logic [127:0] sig,
                                              input int e2);
      int           p, sh, be;
      logic [127:0] m, rem, half;
      p = 0;
      for (int i = 0; i < 128; i++) if (sig[i]) p = i;
      sh = p - 23;
      if (sh < -149 - e2) sh = -149 - e2;
      if (sh >= 128) return {s, 31'd0};
      if (sh > 0) begin
         m    = sig >> sh;
         rem  = sig & ((128'd1 << sh) - 128'd1);
         half = 128'd1 << (sh - 1);
         if (rem > half || (rem == half && m[0])) m = m + 128'd1;
      end else begin
         m = sig << (-sh);
      end
      if (m[24]) begin
         m  = m >> 1;
         sh = sh + 1;
      end
      if (!m[23]) return {s, 31'd0};
      be = e2 + sh + 23 + 127;
      if (be >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(be), m[22:0]};
   endfunction

   function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
      logic [127:0] prod;
      a_nan  = a[30:23] == 8'hFF && a[22:0] != 0;
      b_nan  = b[30:23] == 8'hFF && b[22:0] != 0;
      a_inf  = a[30:23] == 8'hFF && a[22:0] == 0;
      b_inf  = b[30:23] == 8'hFF && b[22:0] == 0;
      a_zero = a[30:23] == 8'h00;
      b_zero = b[30:23] == 8'h00;
      s      = a[31] ^ b[31];
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN;
      if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
      if (a_zero || b_zero) return {s, 31'd0};
      prod = 128'({1'b1, a[22:0]}) * 128'({1'b1, b[22:0]});
      return fp32_round(s, prod, int'(a[30:23]) - 150 + int'(b[30:23]) - 150);
   endfunction

   function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, lost;
      logic [31:0]  big, sml;
      logic [127:0] mb, ms, total;
      int           d;
      a_nan  = a[30:23] == 8'hFF && a[22:0] != 0;
      b_nan  = b[30:23] == 8'hFF && b[22:0] != 0;
      a_inf  = a[30:23] == 8'hFF && a[22:0] == 0;
      b_inf  = b[30:23] == 8'hFF && b[22:0] == 0;
      a_zero = a[30:23] == 8'h00;
      b_zero = b[30:23] == 8'h00;
      if (a_nan || b_nan || (a_inf && b_inf && a[31] != b[31])) return QNAN;
      if (a_inf) return a;
      if (b_inf) return b;
      if (a_zero && b_zero) return {a[31] & b[31], 31'd0};
      if (a_zero) return fp32_fix(b);
      if (b_zero) return fp32_fix(a);
      if (b[30:0] > a[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      d  = int'(big[30:23]) - int'(sml[30:23]);
      // 38 guard bits plus a sticky bit keep the rounding exact
      mb = 128'({1'b1, big[22:0]}) << 38;
      ms = 128'({1'b1, sml[22:0]}) << 38;
      if (d >= 100) begin
         ms = 128'd1;
      end else if (d > 0) begin
         lost = |(ms & ((128'd1 << d) - 128'd1));
         ms   = (ms >> d) | 128'(lost);
      end
      total = (big[31] ^ sml[31]) ? mb - ms : mb + ms;
      if (total == 0) return 32'd0;
      return fp32_round(big[31], total, int'(big[30:23]) - 150 - 38);
   endfunction

   function automatic logic [31:0] fp32_sub(input logic [31:0] a, input logic [31:0] b);
      return fp32_add(a, {~b[31], b[30:0]});
   endfunction

   // Expected output for one vector at the current target length
   function automatic norm_result_type predict_normalize(input logic [3:0][31:0] raw,
                                                         input logic [31:0] tlen);
      norm_result_type  res;
      logic [3:0][31:0] v;
      logic [31:0]      sq, half, r, t;
      logic             good;
      good = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (raw[i][30:23] == 8'hFF) good = 1'b0;
         v[i] = fp32_fix(raw[i]);
      end
      res.comp = raw;
      res.ok   = 1'b0;
      if (!good) return res;
      sq = fp32_mul(v[0], v[0]);
      for (int i = 1; i < 4; i++) sq = fp32_add(sq, fp32_mul(v[i], v[i]));
      // squares are never negative, so only the magnitude against epsilon matters
      if (sq == QNAN || sq[30:0] < FP_EPS[30:0]) return res;
      half = fp32_mul(FP_HALF, sq);
      r    = fp32_fix(RSQRT_MAGIC - (sq >> 1));
      repeat (2) r = fp32_mul(r, fp32_sub(FP_ONE_P5, fp32_mul(fp32_mul(half, r), r)));
      t = fp32_fix(tlen);
      for (int i = 0; i < 4; i++) res.comp[i] = fp32_mul(fp32_mul(v[i], t), r);
      res.ok = 1'b1;
      return res;
   endfunction

   assign pending = expected_q.size();

   // Track the register, check results, then queue expectations for new transfers
   always @(posedge clock) begin
      norm_result_type exp_r;
      if (reset) begin
         length_reg   <= FP_ONE;
         fail_count   <= 0;
         ok_count     <= 0;
         reject_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) length_reg <= csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_out_x !== exp_r.comp[0] || rsp_out_y !== exp_r.comp[1] ||
                   rsp_out_z !== exp_r.comp[2] || rsp_out_w !== exp_r.comp[3] ||
                   rsp_ok !== exp_r.ok) begin
                  fail_count <= fail_count + 1;
                  if (rsp_out_x !== exp_r.comp[0])
                     $error("out_x expected %h got %h", exp_r.comp[0], rsp_out_x);
                  if (rsp_out_y !== exp_r.comp[1])
                     $error("out_y expected %h got %h", exp_r.comp[1], rsp_out_y);
                  if (rsp_out_z !== exp_r.comp[2])
                     $error("out_z expected %h got %h", exp_r.comp[2], rsp_out_z);
                  if (rsp_out_w !== exp_r.comp[3])
                     $error("out_w expected %h got %h", exp_r.comp[3], rsp_out_w);
                  if (rsp_ok !== exp_r.ok)
                     $error("ok expected %b got %b", exp_r.ok, rsp_ok);
               end
               if (exp_r.ok) ok_count <= ok_count + 1;
               else reject_count <= reject_count + 1;
            end
         end
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(),
                              predict_normalize({req_in_w, req_in_z, req_in_y, req_in_x},
                                                length_reg));
      end
   end

endmodule

FILE: test/tb_vector_normalize_fast_rsqrt_top.sv
`timescale 1ns / 1ps
// Testbench top for vector_normalize_fast_rsqrt_top: clock, reset, vector stimulus,
// register phases and verdict. Depends on vnfr_pkg and the scoreboard module.
module tb_vector_normalize_fast_rsqrt_top;
   import vnfr_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 30;
   localparam int PHASE_ITEMS    = 125;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_in_x, req_in_y, req_in_z, req_in_w;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic        rsp_ok;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int          fail_count, pending, ok_count, reject_count;
   int          idle_cycles;
   int          sent_count;
   logic        hold_req;
   logic        no_gaps;

   vector_normalize_fast_rsqrt_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_x   (req_in_x),
      .req_in_y   (req_in_y),
      .req_in_z   (req_in_z),
      .req_in_w   (req_in_w),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_out_w  (rsp_out_w),
      .rsp_ok     (rsp_ok),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   vector_normalize_fast_rsqrt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_x    (req_in_x),
      .req_in_y    (req_in_y),
      .req_in_z    (req_in_z),
      .req_in_w    (req_in_w),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_out_w   (rsp_out_w),
      .rsp_ok      (rsp_ok),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .ok_count    (ok_count),
      .reject_count(reject_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random gap before the next vector, mostly short
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= x;
      req_in_y  <= y;
      req_in_z  <= z;
      req_in_w  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Pause the sender until every result is back, then let the pipe settle
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random component: mostly moderate values, some specials and raw bits
   function automatic logic [31:0] rand_comp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
      if (r < 65) return {1'($urandom), 31'd0};
      if (r < 70) return {1'($urandom), 8'h00, 23'($urandom)};
      if (r < 75) return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom)};
      if (r < 82) return {1'($urandom), 8'($urandom_range(1, 80)), 23'($urandom)};
      if (r < 88) return {1'($urandom), 8'($urandom_range(180, 254)), 23'($urandom)};
      return $urandom;
   endfunction

   task automatic send_random_vector();
      logic [31:0] c[4];
      int dims;
      for (int i = 0; i < 4; i++) c[i] = rand_comp();
      dims = $urandom_range(2, 4);
      // 2D and 3D vectors carry zero in the unused components
      if (dims < 4) c[3] = 32'd0;
      if (dims < 3) c[2] = 32'd0;
      send_vector(c[0], c[1], c[2], c[3]);
   endtask

   // Receiver: random stalls, calm stretches, and a long hold-off on request
   initial begin
      int r;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (no_gaps || r < 70) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(8, 30)) @(posedge clock);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL vector_normalize_fast_rsqrt_top");
            $finish;
         end
      end
   end

   // Main stimulus
   initial begin
      logic [31:0] lengths[8];
      req_valid   <= 1'b0;
      req_in_x    <= 32'd0;
      req_in_y    <= 32'd0;
      req_in_z    <= 32'd0;
      req_in_w    <= 32'd0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 32'd0;
      hold_req     = 1'b0;
      no_gaps      = 1'b0;
      sent_count   = 0;
      reset       <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors at the reset length of 1.0
      send_vector(32'h3F80_0000, 32'd0, 32'd0, 32'd0);
      send_vector(32'd0, 32'hBF80_0000, 32'd0, 32'd0);
      send_vector(32'h4040_0000, 32'h4080_0000, 32'd0, 32'd0);       // 3,4 -> 0.6,0.8
      send_vector(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
      send_vector(32'd0, 32'd0, 32'd0, 32'd0);                         // zero length
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h38D1_B717, 32'h38D1_B717, 32'd0, 32'd0);         // too short
      send_vector(32'h39B5_04F3, 32'd0, 32'd0, 32'd0);                 // near epsilon
      send_vector(32'h39B5_04F4, 32'd0, 32'd0, 32'd0);
      send_vector(32'h7F80_0000, 32'h3F80_0000, 32'd0, 32'd0);         // +inf
      send_vector(32'h3F80_0000, 32'hFF80_0000, 32'd0, 32'd0);         // -inf
      send_vector(32'h3F80_0000, 32'd0, 32'h7FC0_0000, 32'd0);         // NaN
      send_vector(32'h3F80_0000, 32'd0, 32'd0, 32'hFFFF_FFFF);         // NaN, all ones
      send_vector(32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000, 32'd0); // subnormals
      send_vector(32'h007F_FFFF, 32'd0, 32'd0, 32'd0);                 // subnormal only
      send_vector(32'h7F7F_FFFF, 32'd0, 32'd0, 32'd0);                 // length overflows
      send_vector(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
      send_vector(32'h0080_0000, 32'h8080_0000, 32'd0, 32'd0);         // min normal
      send_vector(32'h5F00_0000, 32'h1F00_0000, 32'd0, 32'd0);
      send_vector(32'hC2C8_0000, 32'h42C8_0000, 32'hC2C8_0000, 32'h3DCC_CCCD);
      drain_pipe();

      // Random phases over a range of target lengths, extremes included
      lengths = '{FP_ONE, 32'h4020_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000, 32'hBDCC_CCCD};
      for (int ph = 0; ph < 8; ph++) begin
         write_length(lengths[ph]);
         no_gaps = (ph == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 1 && i == 20) hold_req = 1'b1;  // fills the pipe, stalls the input
            if (ph == 4 && i == 60) drain_pipe();
            send_random_vector();
         end
         drain_pipe();
      end
      write_length(FP_ONE);
      for (int i = 0; i < 30; i++) send_random_vector();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d vectors over 9 target lengths: %0d normalized, %0d passed through.",
               sent_count, ok_count, reject_count);
      if (fail_count == 0) begin
         $display("PASS vector_normalize_fast_rsqrt_top");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL vector_normalize_fast_rsqrt_top");
      end
      $finish;
   end

endmodule
